>>> rtl/gi2q_pkg.sv
package gi2q_pkg;

    localparam int PHASE_BITS_DEF    = 32;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int RATE_W            = 16;
    localparam int QUAT_W            = 16;
    localparam int DEG720_LSB        = 94464;
    // 94464 = 369 * 2^8: shift out the power of two, divide the odd part by reciprocal
    localparam int DEG720_SH         = 8;
    localparam int DEG720_ODD        = DEG720_LSB >> DEG720_SH;
    localparam int DEG720_HALF_SH    = (DEG720_LSB / 2) >> DEG720_SH;
    localparam int DIV_CYCLES        = 4;
    localparam int DIV_LO_W          = 24;
    localparam int RECIP_W           = 25;
    localparam int RECIP_SH          = 33;
    localparam logic [RECIP_W-1:0] RECIP_ODD =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(DEG720_ODD - 1)) / 64'(DEG720_ODD));
    localparam int CORDIC_STEPS      = 30;
    localparam int CORDIC_GAIN_Q30   = 652032874;
    localparam int TRIG_W            = 32;
    localparam int CORDIC_W          = 34;
    localparam int STEP_W            = 5;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } t_gi2q_in;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_gi2q_out;

    typedef struct packed {
        logic              load;
        logic              run;
        logic [STEP_W-1:0] step;
    } t_cordic_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PHASE,
        S_LOAD,
        S_CORDIC,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/gi2q_cordic.sv
module gi2q_cordic #(
    parameter int PHASE_BITS = gi2q_pkg::PHASE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  gi2q_pkg::t_cordic_ctl                 i_ctl,
    input  logic [PHASE_BITS-1:0]                 i_phase,
    output logic signed [gi2q_pkg::TRIG_W-1:0]    o_cos,
    output logic signed [gi2q_pkg::TRIG_W-1:0]    o_sin
);
    import gi2q_pkg::*;

    logic [31:0]                half_turn;
    logic [31:0]                oct_turn;
    logic [1:0]                 r_quad;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [31:0]         r_z;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [31:0]         ang;

    // half-angle as a 32-bit turn fraction
    if (PHASE_BITS >= 32) begin : g_trunc
        assign half_turn = i_phase[PHASE_BITS-1 -: 32];
    end else begin : g_ext
        assign half_turn = {i_phase, {(32-PHASE_BITS){1'b0}}};
    end

    assign oct_turn = half_turn + 32'h2000_0000;
    assign x_sh     = r_x >>> i_ctl.step;
    assign y_sh     = r_y >>> i_ctl.step;
    assign ang      = signed'(atan_turn(i_ctl.step));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quad <= oct_turn[31:30];
            r_x    <= CORDIC_W'(CORDIC_GAIN_Q30);
            r_y    <= '0;
            r_z    <= signed'({2'b00, oct_turn[29:0]}) - 32'sh2000_0000;
        end else if (i_ctl.run) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + ang;
            end
        end
    end

    // fold the quadrant back
    always_comb begin
        unique case (r_quad)
            2'd0: begin
                o_cos = TRIG_W'(r_x);
                o_sin = TRIG_W'(r_y);
            end
            2'd1: begin
                o_cos = TRIG_W'(-r_y);
                o_sin = TRIG_W'(r_x);
            end
            2'd2: begin
                o_cos = TRIG_W'(-r_x);
                o_sin = TRIG_W'(-r_y);
            end
            default: begin
                o_cos = TRIG_W'(r_y);
                o_sin = TRIG_W'(-r_x);
            end
        endcase
    end

endmodule

>>> rtl/gyro_integrate_to_quaternion.sv
// Gyro rate integration to an attitude quaternion. Each input transfer carries three
// signed rate samples (131.2 LSB per degree per tick); x and z are added to and y is
// subtracted from wrapping phase accumulators (one wrap = 720 degrees), and the result
// transfer carries the Euler-to-quaternion (w,x,y,z) in Q2.14 (OUT_FRAC_BITS fraction
// bits), clamped to +-1.0. Each item passes through these steps in order: accept in the
// idle state, scale the three rates by 1/94464 through a two-stage reciprocal multiply,
// update the phases, load the CORDICs, run 30 CORDIC rotations for the three angles side
// by side, form the twelve products through one shared 32x32 multiplier, then load the
// output register. The input side stalls while an item is in work; a finished result
// waits in the output register without blocking a new input, and the output load waits
// while the receiver still holds the previous result.
module gyro_integrate_to_quaternion #(
    parameter int PHASE_BITS    = gi2q_pkg::PHASE_BITS_DEF,
    parameter int OUT_FRAC_BITS = gi2q_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gi2q_pkg::t_gi2q_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gi2q_pkg::t_gi2q_out o_out
);
    import gi2q_pkg::*;

    localparam int CNT_W = STEP_W;
    localparam int A_W   = (PHASE_BITS > 16) ? PHASE_BITS - 16 : 1;
    localparam int LOP_W = DIV_LO_W + RECIP_W;
    // 2^(PHASE_BITS-8) = 369 * STEP_A + STEP_B splits the scaled quotient in two
    localparam longint unsigned STEP_POW = 64'd1 << (PHASE_BITS - DEG720_SH);
    localparam logic [A_W-1:0]      STEP_A = A_W'(STEP_POW / 64'(DEG720_ODD));
    localparam logic [DIV_LO_W-1:0] STEP_B = DIV_LO_W'(STEP_POW % 64'(DEG720_ODD));
    localparam int ACC_W = 34;
    localparam int SH    = 30 - OUT_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RND = (ACC_W'(1) << SH) >> 1;
    localparam int HI_I  = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS);
    localparam int LO_I  = (OUT_FRAC_BITS >= 15) ? -32768 : -(1 << OUT_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HI = ACC_W'(HI_I);
    localparam logic signed [ACC_W-1:0] LO = ACC_W'(LO_I);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    logic in_take, div_run, phase_upd, acc_go, out_load, cnt_clr;
    t_cordic_ctl cordic_ctl;

    // rate scaling lanes
    logic [RATE_W-1:0]     r_mag [3];
    logic [PHASE_BITS-1:0] r_quo [3];
    logic                  r_neg [3];
    logic [PHASE_BITS-1:0] r_hi;
    logic [DIV_LO_W-1:0]   r_lo;
    logic [PHASE_BITS-1:0] hi_prod;
    logic [DIV_LO_W-1:0]   lo_sum;
    logic [LOP_W-1:0]      lo_prod;
    logic [RATE_W-1:0]     lo_quo;
    logic [PHASE_BITS-1:0] inc [3];
    logic [RATE_W-1:0]     mag [3];
    logic signed [RATE_W-1:0] rate [3];

    logic [PHASE_BITS-1:0] r_yaw, r_pitch, r_roll;

    logic signed [TRIG_W-1:0] cy, sy, cp, sp, cr, sr;
    logic signed [TRIG_W-1:0] r_p [4];
    logic signed [TRIG_W-1:0] op_a, op_b;
    logic signed [63:0]       r_prod;
    logic signed [63:0]       prod_rnd;
    logic signed [ACC_W-1:0]  m30;
    logic signed [ACC_W-1:0]  r_acc [4];
    logic                     r_out_valid;
    t_gi2q_out                r_out;

    assign rate[0] = i_in.rate_x;
    assign rate[1] = i_in.rate_y;
    assign rate[2] = i_in.rate_z;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            mag[l] = rate[l][RATE_W-1] ? (~rate[l] + 1'b1) : rate[l];
            inc[l] = r_neg[l] ? (~r_quo[l] + 1'b1) : r_quo[l];
        end
    end

    // |rate| * 2^PHASE_BITS / 94464 rounded = |rate| * STEP_A + (|rate| * STEP_B + 184) / 369
    assign hi_prod = PHASE_BITS'(r_mag[0]) * PHASE_BITS'(STEP_A);
    assign lo_sum  = DIV_LO_W'(r_mag[0]) * STEP_B + DIV_LO_W'(DEG720_HALF_SH);
    assign lo_prod = LOP_W'(r_lo) * LOP_W'(RECIP_ODD);
    assign lo_quo  = lo_prod[RECIP_SH +: RATE_W];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DIV;
            S_DIV:    if (r_cnt == CNT_W'(DIV_CYCLES-1)) n_state = S_PHASE;
            S_PHASE:  n_state = S_LOAD;
            S_LOAD:   n_state = S_CORDIC;
            S_CORDIC: if (r_cnt == CNT_W'(CORDIC_STEPS-1)) n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC:    if (r_cnt == CNT_W'(11)) n_state = S_OUT;
                      else n_state = S_MUL;
            S_OUT:    if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        in_take    = 1'b0;
        div_run    = 1'b0;
        phase_upd  = 1'b0;
        acc_go     = 1'b0;
        out_load   = 1'b0;
        cnt_clr    = 1'b0;
        cordic_ctl = '0;
        cordic_ctl.step = r_cnt[STEP_W-1:0];
        unique case (r_state)
            S_IDLE:   in_take = i_in_valid;
            S_DIV:    div_run = 1'b1;
            S_PHASE:  phase_upd = 1'b1;
            S_LOAD: begin
                cordic_ctl.load = 1'b1;
                cnt_clr         = 1'b1;
            end
            S_CORDIC: begin
                cordic_ctl.run = 1'b1;
                cnt_clr        = (r_cnt == CNT_W'(CORDIC_STEPS-1));
            end
            S_MUL:    ;
            S_ACC:    acc_go = 1'b1;
            S_OUT:    out_load = !r_out_valid || !i_out_stall;
            default:  ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (in_take || cnt_clr || phase_upd) begin
                r_cnt <= '0;
            end else if (div_run || cordic_ctl.run || acc_go) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // two-stage pipe, one lane a cycle: lanes advance through r_mag and r_quo
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int l = 0; l < 3; l++) begin
                r_mag[l] <= mag[l];
                r_neg[l] <= rate[l][RATE_W-1];
            end
        end else if (div_run) begin
            r_mag[0] <= r_mag[1];
            r_mag[1] <= r_mag[2];
            r_hi     <= hi_prod;
            r_lo     <= lo_sum;
            if (r_cnt != '0) begin
                r_quo[0] <= r_quo[1];
                r_quo[1] <= r_quo[2];
                r_quo[2] <= r_hi + PHASE_BITS'(lo_quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
        end else if (phase_upd) begin
            r_yaw   <= r_yaw + inc[0];
            r_pitch <= r_pitch - inc[1];
            r_roll  <= r_roll + inc[2];
        end
    end

    gi2q_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_ctl   (cordic_ctl),
        .i_phase (r_yaw),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    gi2q_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_ctl   (cordic_ctl),
        .i_phase (r_pitch),
        .o_cos   (cp),
        .o_sin   (sp)
    );

    gi2q_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_ctl   (cordic_ctl),
        .i_phase (r_roll),
        .o_cos   (cr),
        .o_sin   (sr)
    );

    // operand schedule for the shared multiplier
    always_comb begin
        unique case (r_cnt[3:0])
            4'd0:    begin op_a = cr;     op_b = cp; end
            4'd1:    begin op_a = sr;     op_b = sp; end
            4'd2:    begin op_a = sr;     op_b = cp; end
            4'd3:    begin op_a = cr;     op_b = sp; end
            4'd4:    begin op_a = r_p[0]; op_b = cy; end
            4'd5:    begin op_a = r_p[1]; op_b = sy; end
            4'd6:    begin op_a = r_p[2]; op_b = cy; end
            4'd7:    begin op_a = r_p[3]; op_b = sy; end
            4'd8:    begin op_a = r_p[3]; op_b = cy; end
            4'd9:    begin op_a = r_p[2]; op_b = sy; end
            4'd10:   begin op_a = r_p[0]; op_b = sy; end
            4'd11:   begin op_a = r_p[1]; op_b = cy; end
            default: begin op_a = '0;     op_b = '0; end
        endcase
    end

    assign prod_rnd = r_prod + 64'sd536870912;
    assign m30      = ACC_W'(prod_rnd >>> 30);

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (cordic_ctl.load) begin
            for (int k = 0; k < 4; k++) r_acc[k] <= '0;
        end else if (acc_go) begin
            unique case (r_cnt[3:0])
                4'd0:  r_p[0] <= TRIG_W'(m30);
                4'd1:  r_p[1] <= TRIG_W'(m30);
                4'd2:  r_p[2] <= TRIG_W'(m30);
                4'd3:  r_p[3] <= TRIG_W'(m30);
                4'd4, 4'd5:   r_acc[0] <= r_acc[0] + m30;
                4'd6:         r_acc[1] <= r_acc[1] + m30;
                4'd7:         r_acc[1] <= r_acc[1] - m30;
                4'd8, 4'd9:   r_acc[2] <= r_acc[2] + m30;
                4'd10:        r_acc[3] <= r_acc[3] + m30;
                4'd11:        r_acc[3] <= r_acc[3] - m30;
                default: ;
            endcase
        end
    end

    function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] v;
        v = (a + RND) >>> SH;
        if (v > HI) v = HI;
        if (v < LO) v = LO;
        return QUAT_W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.quat_w <= to_out(r_acc[0]);
            r_out.quat_x <= to_out(r_acc[1]);
            r_out.quat_y <= to_out(r_acc[2]);
            r_out.quat_z <= to_out(r_acc[3]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_take_starts_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DIV))
        else $error("accepted item did not start the divider");

    a_result_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the output step");

    a_out_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("pending result overwritten");

    a_w_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((ACC_W'(o_out.quat_w) <= HI) && (ACC_W'(o_out.quat_w) >= LO)))
        else $error("quat_w beyond unit bound");

endmodule
